// ===== sv/multidim_histogram_binner_defines.svh =====
// ----------------------------------------------------------------------------
// Histogram binner assertion macros
// Concurrent assertion shorthands shared by the checker of the binner.
// ----------------------------------------------------------------------------
`ifndef MULTIDIM_HISTOGRAM_BINNER_DEFINES_SVH
`define MULTIDIM_HISTOGRAM_BINNER_DEFINES_SVH

// Same-cycle implication, switched off while reset is high.
`define MHB_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("multidim_histogram_binner: assertion failed");

// Next-cycle implication, switched off while reset is high.
`define MHB_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("multidim_histogram_binner: assertion failed");

// Next-cycle implication that is also checked across reset.
`define MHB_ASSERT_NEXT_ALWAYS(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error("multidim_histogram_binner: assertion failed");

`endif

// ===== sv/mhb_pkg.sv =====
// ----------------------------------------------------------------------------
// Histogram binner package
// Widths, codes, state and command types shared by the binner modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mhb_pkg;

   localparam int MAX_DIMS        = 4;
   localparam int HIST_DEPTH      = 65536;
   localparam int COORD_FRAC_BITS = 8;

   localparam int NUM_COORDS = 4;
   localparam int DIM_LIM    = (MAX_DIMS < NUM_COORDS) ? MAX_DIMS : NUM_COORDS;
   localparam int DIM_W      = (NUM_COORDS > 1) ? $clog2(NUM_COORDS) : 1;

   localparam int ADDR_W = $clog2(HIST_DEPTH);
   localparam int LIN_W  = $clog2(HIST_DEPTH + 1);

   localparam int OP_W        = 2;
   localparam int COORD_W     = 24;
   localparam int SIG_IN_W    = 32;
   localparam int ERR_IN_W    = 32;
   localparam int BIN_ADDR_W  = 16;
   localparam int BIN_INDEX_W = 16;
   localparam int SUM_W       = 48;
   localparam int CNT_W       = 32;
   localparam int DIMS_W      = 3;
   localparam int BINS_W      = 13;
   localparam int PROD_W      = LIN_W + BINS_W;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 13;

   localparam logic [OP_W-1:0] OP_ADD        = 2'd0;
   localparam logic [OP_W-1:0] OP_READ       = 2'd1;
   localparam logic [OP_W-1:0] OP_READ_CLEAR = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_DIMS_USED = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BINS_DIM0 = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BINS_DIM1 = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_BINS_DIM2 = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_BINS_DIM3 = 3'd4;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_INDEX,
      ST_FETCH,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic clear_step;
      logic load;
      logic index_step;
      logic fetch;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic clear_done;
      logic req_is_add;
      logic index_last;
      logic out_free;
   } status_type;

   typedef struct packed {
      logic [OP_W-1:0]                       op;
      logic [NUM_COORDS-1:0][COORD_W-1:0]    coord;
      logic [SIG_IN_W-1:0]                   signal_in;
      logic [ERR_IN_W-1:0]                   error_sq_in;
      logic [BIN_ADDR_W-1:0]                 bin_address;
   } req_payload_type;

   typedef struct packed {
      logic                   in_range;
      logic [BIN_INDEX_W-1:0] bin_index;
      logic [SUM_W-1:0]       signal_sum;
      logic [SUM_W-1:0]       error_sum;
      logic [CNT_W-1:0]       event_count;
   } rsp_payload_type;

endpackage

// ===== sv/mhb_req_if.sv =====
// ----------------------------------------------------------------------------
// Histogram binner request channel
// Valid/ready channel carrying one event or one bin read per beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface mhb_req_if;
   import mhb_pkg::*;

   logic                         valid;
   logic                         ready;
   logic [OP_W-1:0]              op;
   logic signed [COORD_W-1:0]    coord_0;
   logic signed [COORD_W-1:0]    coord_1;
   logic signed [COORD_W-1:0]    coord_2;
   logic signed [COORD_W-1:0]    coord_3;
   logic signed [SIG_IN_W-1:0]   signal_in;
   logic [ERR_IN_W-1:0]          error_sq_in;
   logic [BIN_ADDR_W-1:0]        bin_address;

   modport source (
      output valid, op, coord_0, coord_1, coord_2, coord_3,
             signal_in, error_sq_in, bin_address,
      input  ready
   );

   modport sink (
      input  valid, op, coord_0, coord_1, coord_2, coord_3,
             signal_in, error_sq_in, bin_address,
      output ready
   );
endinterface

// ===== sv/mhb_rsp_if.sv =====
// ----------------------------------------------------------------------------
// Histogram binner result channel
// Valid/ready channel carrying one bin result per beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface mhb_rsp_if;
   import mhb_pkg::*;

   logic                        valid;
   logic                        ready;
   logic                        in_range;
   logic [BIN_INDEX_W-1:0]      bin_index;
   logic signed [SUM_W-1:0]     signal_sum;
   logic [SUM_W-1:0]            error_sum;
   logic [CNT_W-1:0]            event_count;

   modport source (
      output valid, in_range, bin_index, signal_sum, error_sum, event_count,
      input  ready
   );

   modport sink (
      input  valid, in_range, bin_index, signal_sum, error_sum, event_count,
      output ready
   );
endinterface

// ===== sv/mhb_csr_if.sv =====
// ----------------------------------------------------------------------------
// Histogram binner register write channel
// Valid/ready channel carrying one register index and value per beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface mhb_csr_if;
   import mhb_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (
      output valid, index, data,
      input  ready
   );

   modport sink (
      input  valid, index, data,
      output ready
   );
endinterface

// ===== sv/mhb_datapath.sv =====
// ----------------------------------------------------------------------------
// Histogram binner datapath
// Configuration registers, index unit, bin memories and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mhb_datapath (
   input  logic                             clock,
   input  logic                             reset,
   input  mhb_pkg::cmd_type                 cmd,
   output mhb_pkg::status_type              status,
   input  mhb_pkg::req_payload_type         req_payload,
   input  logic                             csr_valid,
   input  logic [mhb_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [mhb_pkg::CSR_DATA_W-1:0]   csr_data,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output mhb_pkg::rsp_payload_type         rsp_payload
);
   import mhb_pkg::*;

   // Configuration registers.
   logic [DIMS_W-1:0] dims_used_ff, dims_used_in;
   logic [BINS_W-1:0] bins_ff [NUM_COORDS];
   logic [BINS_W-1:0] bins_in [NUM_COORDS];

   // Captured request.
   logic [OP_W-1:0]                    op_ff, op_in;
   logic [NUM_COORDS-1:0][COORD_W-1:0] coord_ff, coord_in;
   logic [SIG_IN_W-1:0]                signal_ff, signal_in;
   logic [ERR_IN_W-1:0]                error_ff, error_in;
   logic [BIN_ADDR_W-1:0]              bin_addr_ff, bin_addr_in;

   // Index unit.
   logic [DIM_W-1:0] dim_ff, dim_in;
   logic [LIN_W-1:0] lin_ff, lin_in;
   logic [LIN_W-1:0] mult_ff, mult_in;
   logic             reject_ff, reject_in;

   // Fetch results.
   logic                   ok_ff, ok_in;
   logic [ADDR_W-1:0]      mem_addr_ff, mem_addr_in;
   logic [BIN_INDEX_W-1:0] index_ff, index_in;
   logic [SUM_W-1:0]       rd_sig_ff, rd_err_ff;
   logic [CNT_W-1:0]       rd_cnt_ff;

   // Clearing pass and result register.
   logic [ADDR_W-1:0] clr_ff, clr_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_payload_type   rsp_ff, rsp_in;

   // Bin memories.
   logic [SUM_W-1:0] sig_mem [HIST_DEPTH];
   logic [SUM_W-1:0] err_mem [HIST_DEPTH];
   logic [CNT_W-1:0] cnt_mem [HIST_DEPTH];

   logic [COORD_W-1:0] coord_sel;
   logic [BINS_W-1:0]  bins_sel;
   logic [COORD_W-1:0] ix_full;
   logic [BINS_W-1:0]  ix;
   logic               dim_reject;
   logic [PROD_W-1:0]  term, span;
   logic [PROD_W:0]    lin_sum;
   logic [LIN_W-1:0]   lin_step, mult_step;
   logic [DIM_W-1:0]   last_dim;
   logic               is_add;
   logic               addr_valid;
   logic               add_ok;
   logic               out_free;

   logic [SUM_W:0]   sig_sum, err_sum;
   logic [SUM_W-1:0] new_sig, new_err;
   logic [CNT_W-1:0] new_cnt;

   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [SUM_W-1:0]  wr_sig, wr_err;
   logic [CNT_W-1:0]  wr_cnt;

   // Configuration writes; indexes beyond the register list are ignored.
   always_comb begin
      dims_used_in = dims_used_ff;
      for (int d = 0; d < NUM_COORDS; d++) begin
         bins_in[d] = bins_ff[d];
      end
      if (csr_valid) begin
         unique case (csr_index)
            CSR_DIMS_USED: dims_used_in = csr_data[DIMS_W-1:0];
            CSR_BINS_DIM0: bins_in[0]   = csr_data[BINS_W-1:0];
            CSR_BINS_DIM1: bins_in[1]   = csr_data[BINS_W-1:0];
            CSR_BINS_DIM2: bins_in[2]   = csr_data[BINS_W-1:0];
            CSR_BINS_DIM3: bins_in[3]   = csr_data[BINS_W-1:0];
            default: ;
         endcase
      end
   end

   // Last dimension in use: zero counts as one, large values are limited.
   always_comb begin
      if (dims_used_ff == '0) begin
         last_dim = '0;
      end else if (dims_used_ff > DIMS_W'(DIM_LIM)) begin
         last_dim = DIM_W'(DIM_LIM - 1);
      end else begin
         last_dim = DIM_W'(dims_used_ff - DIMS_W'(1));
      end
   end

   // One dimension per step: truncate, range check, accumulate the index.
   // Index and stride saturate at the memory depth; a saturated index is out of range.
   always_comb begin
      coord_sel  = coord_ff[dim_ff];
      bins_sel   = bins_ff[dim_ff];
      ix_full    = {1'b0, coord_sel[COORD_W-2:0]} >> COORD_FRAC_BITS;
      ix         = ix_full[BINS_W-1:0];
      dim_reject = coord_sel[COORD_W-1] || (ix_full >= COORD_W'(bins_sel));
      term       = PROD_W'(mult_ff) * PROD_W'(ix);
      span       = PROD_W'(mult_ff) * PROD_W'(bins_sel);
      lin_sum    = (PROD_W + 1)'(lin_ff) + (PROD_W + 1)'(term);
      lin_step   = (lin_sum >= (PROD_W + 1)'(HIST_DEPTH)) ? LIN_W'(HIST_DEPTH)
                                                         : lin_sum[LIN_W-1:0];
      mult_step  = (span >= PROD_W'(HIST_DEPTH)) ? LIN_W'(HIST_DEPTH)
                                                 : span[LIN_W-1:0];
   end

   assign is_add     = (op_ff == OP_ADD);
   assign addr_valid = (32'(bin_addr_ff) < 32'(HIST_DEPTH));
   assign add_ok     = !reject_ff && (lin_ff < LIN_W'(HIST_DEPTH));
   assign out_free   = !rsp_valid_ff || rsp_ready;

   // Request capture, index steps and fetch.
   always_comb begin
      op_in       = op_ff;
      coord_in    = coord_ff;
      signal_in   = signal_ff;
      error_in    = error_ff;
      bin_addr_in = bin_addr_ff;
      dim_in      = dim_ff;
      lin_in      = lin_ff;
      mult_in     = mult_ff;
      reject_in   = reject_ff;
      ok_in       = ok_ff;
      mem_addr_in = mem_addr_ff;
      index_in    = index_ff;
      priority if (cmd.load) begin
         op_in       = req_payload.op;
         coord_in    = req_payload.coord;
         signal_in   = req_payload.signal_in;
         error_in    = req_payload.error_sq_in;
         bin_addr_in = req_payload.bin_address;
         dim_in      = '0;
         lin_in      = '0;
         mult_in     = LIN_W'(1);
         reject_in   = 1'b0;
      end else if (cmd.index_step) begin
         dim_in = dim_ff + DIM_W'(1);
         if (dim_reject) begin
            reject_in = 1'b1;
         end else begin
            lin_in  = lin_step;
            mult_in = mult_step;
         end
      end else if (cmd.fetch) begin
         if (is_add) begin
            ok_in       = add_ok;
            mem_addr_in = lin_ff[ADDR_W-1:0];
            index_in    = add_ok ? BIN_INDEX_W'(lin_ff) : '0;
         end else begin
            ok_in       = addr_valid;
            mem_addr_in = ADDR_W'(bin_addr_ff);
            index_in    = bin_addr_ff;
         end
      end else begin
      end
   end

   // Saturating updates of the fetched bin.
   always_comb begin
      sig_sum = {rd_sig_ff[SUM_W-1], rd_sig_ff}
              + {{(SUM_W + 1 - SIG_IN_W){signal_ff[SIG_IN_W-1]}}, signal_ff};
      if (sig_sum[SUM_W] != sig_sum[SUM_W-1]) begin
         new_sig = sig_sum[SUM_W] ? {1'b1, {(SUM_W - 1){1'b0}}}
                                  : {1'b0, {(SUM_W - 1){1'b1}}};
      end else begin
         new_sig = sig_sum[SUM_W-1:0];
      end
      err_sum = (SUM_W + 1)'(rd_err_ff) + (SUM_W + 1)'(error_ff);
      new_err = err_sum[SUM_W] ? '1 : err_sum[SUM_W-1:0];
      new_cnt = (rd_cnt_ff == '1) ? rd_cnt_ff : rd_cnt_ff + CNT_W'(1);
   end

   // Memory write port: clearing pass, add write-back or read-and-clear.
   always_comb begin
      wr_en   = cmd.clear_step
             || (cmd.finish && ok_ff && (is_add || (op_ff == OP_READ_CLEAR)));
      wr_addr = cmd.clear_step ? clr_ff : mem_addr_ff;
      if (cmd.clear_step || !is_add) begin
         wr_sig = '0;
         wr_err = '0;
         wr_cnt = '0;
      end else begin
         wr_sig = new_sig;
         wr_err = new_err;
         wr_cnt = new_cnt;
      end
   end

   always_comb begin
      clr_in = cmd.clear_step ? clr_ff + ADDR_W'(1) : clr_ff;

      rsp_in.in_range  = ok_ff;
      rsp_in.bin_index = index_ff;
      if (!ok_ff) begin
         rsp_in.signal_sum  = '0;
         rsp_in.error_sum   = '0;
         rsp_in.event_count = '0;
      end else if (is_add) begin
         rsp_in.signal_sum  = new_sig;
         rsp_in.error_sum   = new_err;
         rsp_in.event_count = new_cnt;
      end else begin
         rsp_in.signal_sum  = rd_sig_ff;
         rsp_in.error_sum   = rd_err_ff;
         rsp_in.event_count = rd_cnt_ff;
      end
      if (!cmd.finish) begin
         rsp_in = rsp_ff;
      end

      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dims_used_ff <= DIMS_W'(1);
         for (int d = 0; d < NUM_COORDS; d++) begin
            bins_ff[d] <= BINS_W'(1);
         end
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         dims_used_ff <= dims_used_in;
         for (int d = 0; d < NUM_COORDS; d++) begin
            bins_ff[d] <= bins_in[d];
         end
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      coord_ff    <= coord_in;
      signal_ff   <= signal_in;
      error_ff    <= error_in;
      bin_addr_ff <= bin_addr_in;
      dim_ff      <= dim_in;
      lin_ff      <= lin_in;
      mult_ff     <= mult_in;
      reject_ff   <= reject_in;
      ok_ff       <= ok_in;
      mem_addr_ff <= mem_addr_in;
      index_ff    <= index_in;
      rsp_ff      <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (cmd.fetch) begin
         rd_sig_ff <= sig_mem[mem_addr_in];
         rd_err_ff <= err_mem[mem_addr_in];
         rd_cnt_ff <= cnt_mem[mem_addr_in];
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         sig_mem[wr_addr] <= wr_sig;
         err_mem[wr_addr] <= wr_err;
         cnt_mem[wr_addr] <= wr_cnt;
      end
   end

   assign status.clear_done = (clr_ff == ADDR_W'(HIST_DEPTH - 1));
   assign status.req_is_add = (req_payload.op == OP_ADD);
   assign status.index_last = (dim_ff == last_dim);
   assign status.out_free   = out_free;

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

// ===== sv/mhb_ctrl.sv =====
// ----------------------------------------------------------------------------
// Histogram binner controller
// Sequences the clearing pass, index steps, bin fetch and write-back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mhb_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  mhb_pkg::status_type status,
   output mhb_pkg::cmd_type    cmd
);
   import mhb_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      cmd       = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (status.clear_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = status.req_is_add ? ST_INDEX : ST_FETCH;
            end
         end
         ST_INDEX: begin
            cmd.index_step = 1'b1;
            if (status.index_last) begin
               state_in = ST_FETCH;
            end
         end
         ST_FETCH: begin
            cmd.fetch = 1'b1;
            state_in  = ST_FINISH;
         end
         ST_FINISH: begin
            // Write-back and result load wait for room in the result register.
            if (status.out_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

endmodule

// ===== sv/multidim_histogram_binner.sv =====
// ----------------------------------------------------------------------------
// Multidimensional histogram binner
// Bins events of up to four dimensions into saturating histogram memories.
// ----------------------------------------------------------------------------
// Each request beat is either an event to add or a read of one bin. An event
// passes through the index unit, which takes one dimension per step for the
// N dimensions in use (1 to 4); its shared multipliers fold one coordinate
// into the linear index per cycle, with dimension 0 varying fastest. Then
// come the registered read of the bin memories and the saturating write-back,
// which waits for room in the result register. A read or read-and-clear
// skips the index unit. After every reset the block first clears all 65536
// bins, one per cycle, and accepts no request until that pass is done;
// register writes are taken throughout, with csr_ready held high.
`timescale 1ns / 1ps

module multidim_histogram_binner (
   input  logic   clock,
   input  logic   reset,
   mhb_req_if.sink   req_if,
   mhb_rsp_if.source rsp_if,
   mhb_csr_if.sink   csr_if
);
   import mhb_pkg::*;

   cmd_type         cmd;
   status_type      status;
   req_payload_type req_payload;
   rsp_payload_type rsp_payload;
   logic            req_ready;
   logic            rsp_valid;

   // The request beat is gathered into one payload word for the datapath.
   assign req_payload.op          = req_if.op;
   assign req_payload.coord[0]    = req_if.coord_0;
   assign req_payload.coord[1]    = req_if.coord_1;
   assign req_payload.coord[2]    = req_if.coord_2;
   assign req_payload.coord[3]    = req_if.coord_3;
   assign req_payload.signal_in   = req_if.signal_in;
   assign req_payload.error_sq_in = req_if.error_sq_in;
   assign req_payload.bin_address = req_if.bin_address;

   assign req_if.ready = req_ready;

   // Register writes never stall; the user is to change the registers only while idle, the block does not enforce it.
   assign csr_if.ready = 1'b1;

   mhb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   mhb_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .req_payload (req_payload),
      .csr_valid   (csr_if.valid),
      .csr_index   (csr_if.index),
      .csr_data    (csr_if.data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_if.ready),
      .rsp_payload (rsp_payload)
   );

   // The result register lets a new request in while a result beat waits.
   assign rsp_if.valid       = rsp_valid;
   assign rsp_if.in_range    = rsp_payload.in_range;
   assign rsp_if.bin_index   = rsp_payload.bin_index;
   assign rsp_if.signal_sum  = rsp_payload.signal_sum;
   assign rsp_if.error_sum   = rsp_payload.error_sum;
   assign rsp_if.event_count = rsp_payload.event_count;

endmodule

// ===== sv/mhb_checker.sv =====
// ----------------------------------------------------------------------------
// Histogram binner checker
// Port-level assertions on the binner, attached to the top level by bind.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "multidim_histogram_binner_defines.svh"

module mhb_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_ready,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic                            rsp_in_range,
   input logic [mhb_pkg::BIN_INDEX_W-1:0] rsp_bin_index,
   input logic [mhb_pkg::SUM_W-1:0]       rsp_signal_sum,
   input logic [mhb_pkg::SUM_W-1:0]       rsp_error_sum,
   input logic [mhb_pkg::CNT_W-1:0]       rsp_event_count
);
   import mhb_pkg::*;

   // The clearing pass holds requests off straight after reset.
   `MHB_ASSERT_NEXT_ALWAYS(a_clear_after_reset, reset, !req_ready)

   // One request is worked on at a time, so an accepted beat closes the door.
   `MHB_ASSERT_NEXT(a_one_at_a_time, req_valid && req_ready, !req_ready)

   // A result that misses the bin carries no sums.
   `MHB_ASSERT_NOW(a_reject_zero, rsp_valid && !rsp_in_range, rsp_signal_sum == '0 && rsp_error_sum == '0 && rsp_event_count == '0)

   // A stalled result beat holds its valid, bin index, signal sum and event count.
   `MHB_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_bin_index) && $stable(rsp_signal_sum) && $stable(rsp_event_count))

endmodule

bind multidim_histogram_binner mhb_checker u_mhb_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_if.valid),
   .req_ready       (req_if.ready),
   .rsp_valid       (rsp_if.valid),
   .rsp_ready       (rsp_if.ready),
   .rsp_in_range    (rsp_if.in_range),
   .rsp_bin_index   (rsp_if.bin_index),
   .rsp_signal_sum  (rsp_if.signal_sum),
   .rsp_error_sum   (rsp_if.error_sum),
   .rsp_event_count (rsp_if.event_count)
);
